[hdl/sbt_pkg.sv]
// Shared types, constants and helper functions for the source byte tokenizer.
package sbt_pkg;

  // Sizes
  localparam int KW_MAX_CHARS = 6;
  localparam int POS_BITS     = 16;
  localparam int LEN_BITS     = 8;
  localparam int KIND_BITS    = 5;
  localparam int KW_IDX_BITS  = $clog2(KW_MAX_CHARS);
  localparam int KW_NUM       = 13;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [LEN_BITS-1:0]  len_t;
  typedef logic [KIND_BITS-1:0] kind_t;
  typedef logic [KW_MAX_CHARS-1:0][7:0] word_t;

  // Scan modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_EQ,
    MODE_BANG
  } mode_t;

  // Token kinds
  localparam kind_t K_IDENT   = 5'd0;
  localparam kind_t K_NUMBER  = 5'd1;
  localparam kind_t K_KW0     = 5'd2;
  localparam kind_t K_ASSIGN  = 5'd15;
  localparam kind_t K_EQ      = 5'd16;
  localparam kind_t K_NEQ     = 5'd17;
  localparam kind_t K_OP0     = 5'd18;
  localparam kind_t K_UNKNOWN = 5'd28;
  localparam kind_t K_END     = 5'd29;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_EQ  = 8'h3d;
  localparam logic [7:0] CH_BANG = 8'h21;

  // Keyword table: text is right-justified, first character in the top byte
  localparam int KW_LEN [KW_NUM] = '{3, 5, 4, 2, 4, 6, 3, 5, 4, 6, 4, 6, 6};
  localparam logic [47:0] KW_TEXT [KW_NUM] = '{
    "var", "alias", "func", "if", "else", "return", "ptr",
    "alloc", "free", "sizeof", "cast", "struct", "inline"
  };

  // One result transaction
  typedef struct packed {
    kind_t kind;
    pos_t  start;
    len_t  length;
    pos_t  line;
    pos_t  column;
    logic  last;
  } res_t;

  // Results produced by one byte, toward the queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       e0;
    res_t       e1;
  } push_t;

  // Queue status toward the scanner and the top level
  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 room;
  } qstat_t;

  function automatic pos_t pos_inc(pos_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic len_t len_inc(len_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // Parallel compare of the held word against every keyword
  function automatic kind_t kw_kind(word_t w, len_t len);
    kind_t k;
    logic  hit;
    k = K_IDENT;
    for (int i = 0; i < KW_NUM; i++) begin
      hit = (len == LEN_BITS'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX_CHARS; j++) begin
        if (j < KW_LEN[i]) begin
          if (w[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]) hit = 1'b0;
        end
      end
      if (hit) k = K_KW0 + KIND_BITS'(i);
    end
    return k;
  endfunction

  function automatic kind_t op_kind(logic [7:0] b);
    kind_t k;
    case (b)
      "+":     k = K_OP0;
      "-":     k = K_OP0 + 5'd1;
      "*":     k = K_OP0 + 5'd2;
      "/":     k = K_OP0 + 5'd3;
      "(":     k = K_OP0 + 5'd4;
      ")":     k = K_OP0 + 5'd5;
      "{":     k = K_OP0 + 5'd6;
      "}":     k = K_OP0 + 5'd7;
      ",":     k = K_OP0 + 5'd8;
      ";":     k = K_OP0 + 5'd9;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

[hdl/sbt_scan.sv]
// Input register, scan state and single-pass token classification.
module sbt_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_char_in,
  input  sbt_pkg::qstat_t qstat,
  output sbt_pkg::push_t  push
);

  // Input register
  logic       s_vld_r;
  logic [7:0] s_char_r;
  logic       advance;

  // Scan state
  sbt_pkg::mode_t mode_r, mode_nxt;
  sbt_pkg::word_t word_r, word_nxt;
  sbt_pkg::len_t  plen_r, plen_nxt;
  sbt_pkg::pos_t  pstart_r, pstart_nxt;
  sbt_pkg::pos_t  pcol_r, pcol_nxt;
  sbt_pkg::pos_t  pos_r, pos_nxt;
  sbt_pkg::pos_t  line_r, line_nxt;
  sbt_pkg::pos_t  col_r, col_nxt;

  // Working values
  logic [7:0]    b;
  sbt_pkg::pos_t pos_b, line_b, col_b;
  logic          fl_v, mn_v, consume;
  sbt_pkg::res_t fl, mn;

  assign advance  = s_vld_r && qstat.room;
  assign in_stall = s_vld_r && !qstat.room;
  assign b        = s_char_r;

  // Position counters after this byte
  always_comb begin
    pos_b  = sbt_pkg::pos_inc(pos_r);
    line_b = (b == sbt_pkg::CH_LF) ? sbt_pkg::pos_inc(line_r) : line_r;
    col_b  = (b == sbt_pkg::CH_LF) ? sbt_pkg::POS_BITS'(1) : sbt_pkg::pos_inc(col_r);
  end

  // Next state and results for the byte in the input register
  always_comb begin
    mode_nxt   = mode_r;
    word_nxt   = word_r;
    plen_nxt   = plen_r;
    pstart_nxt = pstart_r;
    pcol_nxt   = pcol_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    fl_v       = 1'b0;
    mn_v       = 1'b0;
    consume    = 1'b1;
    fl         = '0;
    mn         = '0;
    fl.line    = line_r;
    mn.line    = line_r;

    // Pending token: extend it or flush it
    case (mode_r)
      sbt_pkg::MODE_WORD: begin
        if (sbt_pkg::is_word(b)) begin
          if (plen_r < sbt_pkg::LEN_BITS'(sbt_pkg::KW_MAX_CHARS)) begin
            word_nxt[plen_r[sbt_pkg::KW_IDX_BITS-1:0]] = b;
          end
          plen_nxt = sbt_pkg::len_inc(plen_r);
          pos_nxt  = pos_b;
          line_nxt = line_b;
          col_nxt  = col_b;
          consume  = 1'b0;
        end else begin
          fl_v      = 1'b1;
          fl.kind   = sbt_pkg::kw_kind(word_r, plen_r);
          fl.start  = pstart_r;
          fl.length = plen_r;
          fl.column = pcol_r;
        end
      end
      sbt_pkg::MODE_NUMBER: begin
        if (sbt_pkg::is_digit(b) || b == ".") begin
          plen_nxt = sbt_pkg::len_inc(plen_r);
          pos_nxt  = pos_b;
          line_nxt = line_b;
          col_nxt  = col_b;
          consume  = 1'b0;
        end else begin
          fl_v      = 1'b1;
          fl.kind   = sbt_pkg::K_NUMBER;
          fl.start  = pstart_r;
          fl.length = plen_r;
          fl.column = pcol_r;
        end
      end
      sbt_pkg::MODE_EQ, sbt_pkg::MODE_BANG: begin
        if (b == sbt_pkg::CH_EQ) begin
          // two-character comparison
          mode_nxt  = sbt_pkg::MODE_IDLE;
          pos_nxt   = pos_b;
          line_nxt  = line_b;
          col_nxt   = col_b;
          consume   = 1'b0;
          mn_v      = 1'b1;
          mn.kind   = (mode_r == sbt_pkg::MODE_EQ) ? sbt_pkg::K_EQ : sbt_pkg::K_NEQ;
          mn.start  = pstart_r;
          mn.length = sbt_pkg::LEN_BITS'(2);
          mn.column = pcol_r;
        end else begin
          fl_v      = 1'b1;
          fl.kind   = (mode_r == sbt_pkg::MODE_EQ) ? sbt_pkg::K_ASSIGN : sbt_pkg::K_UNKNOWN;
          fl.start  = pstart_r;
          fl.length = sbt_pkg::LEN_BITS'(1);
          fl.column = pcol_r;
        end
      end
      default: ;
    endcase

    // Byte handled from idle
    if (consume) begin
      mode_nxt = sbt_pkg::MODE_IDLE;
      if (b == sbt_pkg::CH_NUL) begin
        mn_v      = 1'b1;
        mn.kind   = sbt_pkg::K_END;
        mn.start  = pos_r;
        mn.length = '0;
        mn.column = col_r;
        pos_nxt   = '0;
        line_nxt  = sbt_pkg::POS_BITS'(1);
        col_nxt   = sbt_pkg::POS_BITS'(1);
        plen_nxt  = '0;
      end else if (sbt_pkg::is_space(b)) begin
        pos_nxt  = pos_b;
        line_nxt = line_b;
        col_nxt  = col_b;
      end else if (sbt_pkg::is_alpha(b) || sbt_pkg::is_digit(b) || b == "_" ||
                   b == sbt_pkg::CH_EQ || b == sbt_pkg::CH_BANG) begin
        if (sbt_pkg::is_digit(b)) begin
          mode_nxt = sbt_pkg::MODE_NUMBER;
        end else if (b == sbt_pkg::CH_EQ) begin
          mode_nxt = sbt_pkg::MODE_EQ;
        end else if (b == sbt_pkg::CH_BANG) begin
          mode_nxt = sbt_pkg::MODE_BANG;
        end else begin
          mode_nxt    = sbt_pkg::MODE_WORD;
          word_nxt[0] = b;
        end
        pstart_nxt = pos_r;
        pcol_nxt   = col_r;
        plen_nxt   = sbt_pkg::LEN_BITS'(1);
        pos_nxt    = pos_b;
        line_nxt   = line_b;
        col_nxt    = col_b;
      end else begin
        mn_v      = 1'b1;
        mn.kind   = sbt_pkg::op_kind(b);
        mn.start  = pos_r;
        mn.length = sbt_pkg::LEN_BITS'(1);
        mn.column = col_r;
        pos_nxt   = pos_b;
        line_nxt  = line_b;
        col_nxt   = col_b;
      end
    end
  end

  // Pack the results in order, marking the last one
  always_comb begin
    push = '0;
    if (fl_v) begin
      push.e0      = fl;
      push.e0.last = !mn_v;
      push.e1      = mn;
      push.e1.last = 1'b1;
      push.cnt     = mn_v ? 2'd2 : 2'd1;
    end else begin
      push.e0      = mn;
      push.e0.last = 1'b1;
      push.e1      = mn;
      push.e1.last = 1'b1;
      push.cnt     = mn_v ? 2'd1 : 2'd0;
    end
    if (!advance) push.cnt = 2'd0;
  end

  // Input register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r  <= 1'b0;
      mode_r   <= sbt_pkg::MODE_IDLE;
      plen_r   <= '0;
      pstart_r <= '0;
      pcol_r   <= sbt_pkg::POS_BITS'(1);
      pos_r    <= '0;
      line_r   <= sbt_pkg::POS_BITS'(1);
      col_r    <= sbt_pkg::POS_BITS'(1);
    end else begin
      if (!in_stall) s_vld_r <= in_valid;
      if (advance) begin
        mode_r   <= mode_nxt;
        plen_r   <= plen_nxt;
        pstart_r <= pstart_nxt;
        pcol_r   <= pcol_nxt;
        pos_r    <= pos_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s_char_r <= in_char_in;
    if (advance) word_r <= word_nxt;
  end

endmodule

[hdl/sbt_outq.sv]
// Small result queue: takes up to two results a cycle, delivers one while out_stall is low.
module sbt_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  sbt_pkg::push_t  push,
  output sbt_pkg::qstat_t qstat,
  output logic            out_valid,
  input  logic            out_stall,
  output sbt_pkg::res_t   out_res
);

  sbt_pkg::res_t                  q_r [sbt_pkg::QUEUE_DEPTH];
  logic [sbt_pkg::QPTR_BITS-1:0]  wp_r, rp_r;
  logic [sbt_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                           pop;

  assign out_valid   = (cnt_r != '0);
  assign pop         = out_valid && !out_stall;
  assign out_res     = q_r[rp_r];
  assign qstat.count = cnt_r;
  // room for a full pair of results
  assign qstat.room  = (cnt_r <= sbt_pkg::QCNT_BITS'(sbt_pkg::QUEUE_DEPTH - 2));

  assign cnt_nxt = cnt_r + sbt_pkg::QCNT_BITS'(push.cnt)
                   - sbt_pkg::QCNT_BITS'(pop);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + sbt_pkg::QPTR_BITS'(push.cnt);
      rp_r  <= rp_r + sbt_pkg::QPTR_BITS'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wp_r] <= push.e0;
    if (push.cnt == 2'd2) q_r[wp_r + sbt_pkg::QPTR_BITS'(1)] <= push.e1;
  end

endmodule

[hdl/source_byte_tokenizer.sv]
// Top level of the source byte tokenizer.
//
// Usage: source bytes enter on the in_ channel, one per transaction; a zero
// byte ends the source, flushes any pending token and emits an end token.
// Tokens leave on the out_ channel, one per transaction, in source order;
// out_last_of_run marks the final token caused by one byte.
// A byte accepted into the input register is classified there and its
// tokens are written into the result queue, which offers the first one to
// the receiver; a queue without room holds the byte in the input register.
// Throughput: one byte per cycle while the receiver keeps up; a byte gives
// zero, one or two tokens, and the output port moves one token a cycle,
// so bytes that give two tokens are paced by the four-entry result queue.
// in_stall rises when the byte in the input register cannot be classified
// because the queue lacks room for two tokens.
// Reset (synchronous, active low) returns the scanner to idle, offset 0,
// line 1, column 1, and empties the queue. A stalled receiver holds the
// current token steady; bytes keep entering until the queue lacks room for two.
module source_byte_tokenizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbt_pkg::KIND_BITS-1:0] out_token_kind,
  output logic [sbt_pkg::POS_BITS-1:0]  out_token_start,
  output logic [sbt_pkg::LEN_BITS-1:0]  out_token_length,
  output logic [sbt_pkg::POS_BITS-1:0]  out_token_line,
  output logic [sbt_pkg::POS_BITS-1:0]  out_token_column,
  output logic                          out_last_of_run
);

  sbt_pkg::push_t  push;
  sbt_pkg::qstat_t qstat;
  sbt_pkg::res_t   res;

  sbt_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .qstat      (qstat),
    .push       (push)
  );

  sbt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .qstat     (qstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Result fields
  assign out_token_kind   = res.kind;
  assign out_token_start  = res.start;
  assign out_token_length = res.length;
  assign out_token_line   = res.line;
  assign out_token_column = res.column;
  assign out_last_of_run  = res.last;

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= sbt_pkg::QCNT_BITS'(sbt_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token offered after reset");

  // An end token always closes its byte's run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == sbt_pkg::K_END) |-> out_last_of_run)
    else $error("end token not last of run");

  // Two-character comparisons are two bytes long and close the run
  a_cmp_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == sbt_pkg::K_EQ || out_token_kind == sbt_pkg::K_NEQ))
    |-> (out_token_length == sbt_pkg::LEN_BITS'(2) && out_last_of_run))
    else $error("bad comparison token");

endmodule
